// File: src/tpq_pkg.sv
// Shared types, widths and codes for the three-class priority queue
`default_nettype none
package tpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int MODE_W   = 2;
    localparam int CLASS_W  = 2;
    localparam int ID_W     = 37;
    localparam int ITEMS_W  = 10;
    localparam int HANDLE_W = 8;
    localparam int STAT_W   = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_HIGH = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_UNDER  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd6;

    typedef struct packed {
        logic [CLASS_W-1:0]  cls;
        logic [ID_W-1:0]     id;
        logic [ITEMS_W-1:0]  items;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic            load;
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
    } sts_t;

endpackage
`default_nettype wire

// File: src/three_class_priority_queue_core.sv
// Top level of the three-class priority queue
// Flow: start loads the operands and enters the execute state; the result registers and done follow it.
// A new start is taken in idle or while done is shown, not while busy; busy is high in the execute state.
// The insert and remove shifts move every cell of the chain at once.
// Reset clears the entry count and the controller; the entry cells are not reset.
// Results are strobed for one cycle by done; the receiver cannot stall.
`default_nettype none
module three_class_priority_queue_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tpq_pkg::MODE_W-1:0]   mode,
    input  wire logic [tpq_pkg::CLASS_W-1:0]  priority_class,
    input  wire logic [tpq_pkg::ID_W-1:0]     customer_id,
    input  wire logic [tpq_pkg::ITEMS_W-1:0]  item_count,
    input  wire logic [tpq_pkg::HANDLE_W-1:0] name_handle,
    output logic                              done,
    output logic [tpq_pkg::STAT_W-1:0]        status,
    output logic                              out_valid,
    output logic [tpq_pkg::ID_W-1:0]          out_customer_id,
    output logic [tpq_pkg::CLASS_W-1:0]       out_priority_class,
    output logic [tpq_pkg::ITEMS_W-1:0]       out_item_count,
    output logic [tpq_pkg::HANDLE_W-1:0]      out_name_handle,
    output logic [tpq_pkg::CNT_W-1:0]         occupancy
);
    import tpq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tpq_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .mode               (mode),
        .priority_class     (priority_class),
        .customer_id        (customer_id),
        .item_count         (item_count),
        .name_handle        (name_handle),
        .status             (status),
        .out_valid          (out_valid),
        .out_customer_id    (out_customer_id),
        .out_priority_class (out_priority_class),
        .out_item_count     (out_item_count),
        .out_name_handle    (out_name_handle),
        .occupancy          (occupancy)
    );

endmodule
`default_nettype wire

// File: src/tpq_ctrl.sv
// Controller state machine: sequences load, execute and result transfer
`default_nettype none
module tpq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire tpq_pkg::sts_t sts,
    output tpq_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               done
);
    import tpq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE, ST_RESP:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                case (sts.mode)
                    MODE_INSERT: cmd.op = sts.full ? OP_DROP : OP_INSERT;
                    MODE_REMOVE: cmd.op = sts.empty ? OP_UNDER : OP_REMOVE;
                    MODE_CLEAR:  cmd.op = OP_CLEAR;
                    default:     cmd.op = OP_NOP;
                endcase
                state_next = ST_RESP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = (state_reg == ST_RESP);

`ifndef SYNTHESIS
    a_exec_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execute not followed by result");
    a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without execute");
    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy && cmd.op == OP_NONE)
        else $error("load while executing");
`endif

endmodule
`default_nettype wire

// File: src/tpq_dp.sv
// Datapath: operand latch, shift-insert cell chain, count and result registers
`default_nettype none
module tpq_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tpq_pkg::cmd_t             cmd,
    output tpq_pkg::sts_t                  sts,
    input  wire logic [tpq_pkg::MODE_W-1:0]   mode,
    input  wire logic [tpq_pkg::CLASS_W-1:0]  priority_class,
    input  wire logic [tpq_pkg::ID_W-1:0]     customer_id,
    input  wire logic [tpq_pkg::ITEMS_W-1:0]  item_count,
    input  wire logic [tpq_pkg::HANDLE_W-1:0] name_handle,
    output logic [tpq_pkg::STAT_W-1:0]        status,
    output logic                              out_valid,
    output logic [tpq_pkg::ID_W-1:0]          out_customer_id,
    output logic [tpq_pkg::CLASS_W-1:0]       out_priority_class,
    output logic [tpq_pkg::ITEMS_W-1:0]       out_item_count,
    output logic [tpq_pkg::HANDLE_W-1:0]      out_name_handle,
    output logic [tpq_pkg::CNT_W-1:0]         occupancy
);
    import tpq_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    entry_t            new_reg;
    entry_t            new_next;

    entry_t            entry_reg  [CAPACITY];
    entry_t            entry_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CAPACITY-1:0] behind;

    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              valid_reg;
    logic              valid_next;
    entry_t            out_reg;
    entry_t            out_next;

    always_comb
    begin
        new_next        = new_reg;
        new_next.id     = customer_id;
        new_next.items  = item_count;
        new_next.handle = name_handle;
        if (priority_class == CLASS_HIGH || priority_class == CLASS_MID)
        begin
            new_next.cls = priority_class;
        end
        else
        begin
            new_next.cls = CLASS_LOW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            new_reg  <= new_next;
        end
    end

    assign sts.mode  = mode_reg;
    assign sts.full  = (count_reg == CNT_W'(CAPACITY));
    assign sts.empty = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            behind[i] = (CNT_W'(i) >= count_reg) || (entry_reg[i].cls > new_reg.cls);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        count_next  = count_reg;
        status_next = status_reg;
        valid_next  = valid_reg;
        out_next    = out_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                entry_next[0] = behind[0] ? new_reg : entry_reg[0];
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (behind[i] && !behind[i-1])
                    begin
                        entry_next[i] = new_reg;
                    end
                    else if (behind[i])
                    begin
                        entry_next[i] = entry_reg[i-1];
                    end
                end
                count_next  = count_reg + 1'b1;
                status_next = STAT_OK;
                valid_next  = 1'b0;
                out_next    = '0;
            end
            OP_DROP:
            begin
                status_next = STAT_FULL;
                valid_next  = 1'b0;
                out_next    = '0;
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    entry_next[i] = entry_reg[i+1];
                end
                count_next  = count_reg - 1'b1;
                status_next = STAT_OK;
                valid_next  = 1'b1;
                out_next    = entry_reg[0];
            end
            OP_UNDER:
            begin
                status_next = STAT_EMPTY;
                valid_next  = 1'b0;
                out_next    = '0;
            end
            OP_CLEAR:
            begin
                count_next  = '0;
                status_next = STAT_OK;
                valid_next  = 1'b0;
                out_next    = '0;
            end
            OP_NOP:
            begin
                status_next = STAT_OK;
                valid_next  = 1'b0;
                out_next    = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= STAT_OK;
            valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            valid_reg  <= valid_next;
        end
    end

    assign status             = status_reg;
    assign out_valid          = valid_reg;
    assign out_customer_id    = out_reg.id;
    assign out_priority_class = out_reg.cls;
    assign out_item_count     = out_reg.items;
    assign out_name_handle    = out_reg.handle;
    assign occupancy          = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INSERT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow queue");
    a_remove_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_REMOVE |=> valid_reg && out_reg == $past(entry_reg[0]))
        else $error("remove did not return head");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_CLEAR |=> count_reg == '0)
        else $error("clear left entries");
`endif

endmodule
`default_nettype wire
